// File: rtl/core/qslerp_pkg.sv
package qslerp_pkg;

	localparam int FracBitsDef    = 14;
	localparam int CordicStepsDef = 16;
	localparam int MaxSteps       = 28;
	localparam int Wf             = 30;
	localparam int DatW           = 36;
	localparam int SqW            = 31;
	localparam int NearResetVal   = 16382;

	localparam logic signed [DatW-1:0] GainW   = 36'sd652032874;
	localparam logic signed [DatW-1:0] OneW    = 36'sd1073741824;
	localparam logic signed [DatW-1:0] TwoOneW = 36'sd2147483648;

	// arctangent of 2^-i, 30 fraction bits
	function automatic logic signed [DatW-1:0] atan_w(input int idx);
		logic signed [DatW-1:0] v;
		begin
			unique case (idx)
				0:  v = 36'sd843314857;
				1:  v = 36'sd497837829;
				2:  v = 36'sd263043837;
				3:  v = 36'sd133525159;
				4:  v = 36'sd67021687;
				5:  v = 36'sd33543516;
				6:  v = 36'sd16775851;
				7:  v = 36'sd8388437;
				8:  v = 36'sd4194283;
				9:  v = 36'sd2097149;
				10: v = 36'sd1048576;
				11: v = 36'sd524288;
				12: v = 36'sd262144;
				13: v = 36'sd131072;
				14: v = 36'sd65536;
				15: v = 36'sd32768;
				16: v = 36'sd16384;
				17: v = 36'sd8192;
				18: v = 36'sd4096;
				19: v = 36'sd2048;
				20: v = 36'sd1024;
				21: v = 36'sd512;
				22: v = 36'sd256;
				23: v = 36'sd128;
				24: v = 36'sd64;
				25: v = 36'sd32;
				26: v = 36'sd16;
				27: v = 36'sd8;
				default: v = '0;
			endcase
			return v;
		end
	endfunction

	// per-request payload carried along the chain
	typedef struct packed {
		logic signed [15:0] a_x, a_y, a_z, a_w;
		logic signed [15:0] b_x, b_y, b_z, b_w;
		logic [24:0]        t;
		logic               lin;
		logic               flip;
	} qs_side_t;

endpackage

// File: rtl/core/qslerp_sqrt_cell.sv
// one restoring square root step: two radicand bits, one root bit
module qslerp_sqrt_cell #(
	parameter int Idx = 0
) (
	input  logic                             clk,
	input  logic [2*qslerp_pkg::SqW-1:0]     rad_i,
	input  logic [qslerp_pkg::SqW+1:0]       rem_i,
	input  logic [qslerp_pkg::SqW-1:0]       root_i,
	output logic [2*qslerp_pkg::SqW-1:0]     rad_q,
	output logic [qslerp_pkg::SqW+1:0]       rem_q,
	output logic [qslerp_pkg::SqW-1:0]       root_q
);
	localparam int W = qslerp_pkg::SqW;

	logic [W+1:0] trial;
	logic [W+1:0] cand;

	// shift in next radicand pair, try subtract
	always_comb begin
		trial = {rem_i[W-1:0], rad_i[2*W-1-2*Idx -: 2]};
		cand  = {root_i, 2'b01};
	end

	always_ff @(posedge clk) begin
		rad_q <= rad_i;
		if (trial >= cand) begin
			rem_q  <= trial - cand;
			root_q <= {root_i[W-2:0], 1'b1};
		end else begin
			rem_q  <= trial;
			root_q <= {root_i[W-2:0], 1'b0};
		end
	end
endmodule

// File: rtl/core/qslerp_cordic_cell.sv
// one cordic micro-rotation, vectoring (angle) or rotation (sine) mode
module qslerp_cordic_cell #(
	parameter int Idx = 0,
	parameter bit Vec = 1'b0
) (
	input  logic                                   clk,
	input  logic signed [qslerp_pkg::DatW-1:0]     x_i,
	input  logic signed [qslerp_pkg::DatW-1:0]     y_i,
	input  logic signed [qslerp_pkg::DatW-1:0]     z_i,
	output logic signed [qslerp_pkg::DatW-1:0]     x_q,
	output logic signed [qslerp_pkg::DatW-1:0]     y_q,
	output logic signed [qslerp_pkg::DatW-1:0]     z_q
);
	localparam logic signed [qslerp_pkg::DatW-1:0] Ang = qslerp_pkg::atan_w(Idx);

	logic signed [qslerp_pkg::DatW-1:0] dx, dy;
	logic pos;

	// direction from y sign (vectoring) or z sign (rotation)
	always_comb begin
		dx  = y_i >>> Idx;
		dy  = x_i >>> Idx;
		pos = Vec ? !y_i[qslerp_pkg::DatW-1] : !z_i[qslerp_pkg::DatW-1];
	end

	always_ff @(posedge clk) begin
		if (Vec ? pos : !pos) begin
			x_q <= x_i + dx;
			y_q <= y_i - dy;
		end else begin
			x_q <= x_i - dx;
			y_q <= y_i + dy;
		end
		z_q <= (Vec ? pos : !pos) ? (Vec ? z_i + Ang : z_i + Ang) : z_i - Ang;
	end
endmodule

// File: rtl/core/qslerp_div_cell.sv
// one restoring division step for an unsigned quotient bit
module qslerp_div_cell #(
	parameter int Idx = 0
) (
	input  logic                                clk,
	input  logic [63:0]                         num_i,
	input  logic [qslerp_pkg::SqW:0]            rem_i,
	input  logic [qslerp_pkg::SqW-1:0]          den_i,
	input  logic [33:0]                         quo_i,
	output logic [63:0]                         num_q,
	output logic [qslerp_pkg::SqW:0]            rem_q,
	output logic [qslerp_pkg::SqW-1:0]          den_q,
	output logic [33:0]                         quo_q
);
	localparam int W = qslerp_pkg::SqW;

	logic [W+1:0] trial;

	always_comb trial = {rem_i, num_i[63-Idx]};

	// subtract divisor if it fits, saturate quotient width
	always_ff @(posedge clk) begin
		num_q <= num_i;
		den_q <= den_i;
		if (trial >= {2'b00, den_i}) begin
			rem_q <= (W+1)'(trial - {2'b00, den_i});
			quo_q <= {quo_i[32:0], 1'b1} | {33'd0, (|quo_i[33:32])} << 33;
		end else begin
			rem_q <= trial[W:0];
			quo_q <= {quo_i[32:0], 1'b0} | {33'd0, (|quo_i[33:32])} << 33;
		end
	end
endmodule

// File: rtl/core/quaternion_slerp_core.sv
// request  | ports                               | dir | qualifier
// input    | a_*, b_*, t_frac                    | in  | start && !busy
// output   | r_*, used_linear, flipped           | out | done (one cycle)
// config   | cfg_data                            | in  | cfg_we
//
// one request per cycle; each request passes through the chain of square root,
// cordic and divider cells.
// busy is tied low: the chain advances every cycle.
// arst_n clears the valid chain and loads the threshold register with NearResetVal.
// the receiver cannot stall; done pulses for one cycle per request.
module quaternion_slerp_core #(
	parameter int FRAC_BITS    = qslerp_pkg::FracBitsDef,
	parameter int CORDIC_STEPS = qslerp_pkg::CordicStepsDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               cfg_we,
	input  logic [14:0]        cfg_data,
	input  logic signed [15:0] a_x, a_y, a_z, a_w,
	input  logic signed [15:0] b_x, b_y, b_z, b_w,
	input  logic [14:0]        t_frac,
	output logic               done,
	output logic signed [15:0] r_x, r_y, r_z, r_w,
	output logic               used_linear,
	output logic               flipped
);
	localparam int DW   = qslerp_pkg::DatW;
	localparam int SW   = qslerp_pkg::SqW;
	localparam int NST  = (CORDIC_STEPS > qslerp_pkg::MaxSteps) ?
		qslerp_pkg::MaxSteps : CORDIC_STEPS;
	localparam int SH   = qslerp_pkg::Wf - FRAC_BITS;
	localparam int DIVN = 64;
	localparam int LAT  = 3 + SW + 1 + NST + 1 + NST + DIVN + 2;
	localparam logic [24:0] OneF = 25'd1 << FRAC_BITS;

	typedef qslerp_pkg::qs_side_t side_t;

	logic [14:0] near_q;
	logic [LAT-1:0] vld_q;

	assign busy = 1'b0;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) near_q <= 15'(qslerp_pkg::NearResetVal);
		else if (cfg_we) near_q <= cfg_data;
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[LAT-2:0], start};
	end

	// stage 1: products
	logic signed [31:0] p_s1 [4];
	side_t sd_s1;
	always_ff @(posedge clk) begin
		p_s1[0] <= a_x * b_x;
		p_s1[1] <= a_y * b_y;
		p_s1[2] <= a_z * b_z;
		p_s1[3] <= a_w * b_w;
		sd_s1.a_x <= a_x; sd_s1.a_y <= a_y; sd_s1.a_z <= a_z; sd_s1.a_w <= a_w;
		sd_s1.b_x <= b_x; sd_s1.b_y <= b_y; sd_s1.b_z <= b_z; sd_s1.b_w <= b_w;
		sd_s1.t <= ({10'd0, t_frac} > OneF) ? OneF : {10'd0, t_frac};
		sd_s1.lin <= 1'b0;
		sd_s1.flip <= 1'b0;
	end

	// stage 2: dot, flip, cosine (b is negated later, in the blend)
	logic signed [33:0] dot;
	logic [33:0] mag;
	logic [24:0] c_s2;
	side_t sd_n2;
	side_t sd_s2;
	always_comb begin
		dot = 34'(p_s1[0]) + 34'(p_s1[1]) + 34'(p_s1[2]) + 34'(p_s1[3]);
		mag = dot[33] ? 34'(-dot) : 34'(dot);
		sd_n2 = sd_s1;
		sd_n2.flip = dot[33];
	end
	always_ff @(posedge clk) begin
		sd_s2 <= sd_n2;
		c_s2 <= ((mag >> FRAC_BITS) > 34'(OneF)) ? OneF : 25'(mag >> FRAC_BITS);
	end

	// stage 3: linear decision and sqrt radicand
	logic [2*SW-1:0] rad_s3;
	logic [24:0] c_s3;
	side_t sd_n3;
	side_t sd_s3;
	logic [49:0] csq;
	always_comb begin
		csq = 50'(c_s2) * 50'(c_s2);
		sd_n3 = sd_s2;
		sd_n3.lin = c_s2 > 25'(near_q);
	end
	always_ff @(posedge clk) begin
		sd_s3 <= sd_n3;
		c_s3 <= c_s2;
		rad_s3 <= 62'((50'(OneF) * 50'(OneF) - csq)) << (60 - 2 * FRAC_BITS);
	end

	// square root chain
	logic [2*SW-1:0] srad [SW+1];
	logic [SW+1:0]   srem [SW+1];
	logic [SW-1:0]   sroot [SW+1];
	side_t sqsd [SW+1];
	logic [24:0] sqc [SW+1];
	assign srad[0] = rad_s3;
	assign srem[0] = '0;
	assign sroot[0] = '0;
	assign sqsd[0] = sd_s3;
	assign sqc[0] = c_s3;
	for (genvar g = 0; g < SW; g++) begin : g_sq
		qslerp_sqrt_cell #(.Idx(g)) u_cell (
			.clk(clk), .rad_i(srad[g]), .rem_i(srem[g]), .root_i(sroot[g]),
			.rad_q(srad[g+1]), .rem_q(srem[g+1]), .root_q(sroot[g+1]));
		always_ff @(posedge clk) begin
			sqsd[g+1] <= sqsd[g];
			sqc[g+1] <= sqc[g];
		end
	end

	// vectoring chain: angle
	logic signed [DW-1:0] vx [NST+1], vy [NST+1], vz [NST+1];
	side_t vsd [NST+1];
	logic [SW-1:0] vs [NST+1];
	assign vx[0] = DW'(sqc[SW]) << SH;
	assign vy[0] = DW'(sroot[SW]);
	assign vz[0] = '0;
	assign vsd[0] = sqsd[SW];
	assign vs[0] = sroot[SW];
	for (genvar g = 0; g < NST; g++) begin : g_vec
		qslerp_cordic_cell #(.Idx(g), .Vec(1'b1)) u_cell (
			.clk(clk), .x_i(vx[g]), .y_i(vy[g]), .z_i(vz[g]),
			.x_q(vx[g+1]), .y_q(vy[g+1]), .z_q(vz[g+1]));
		always_ff @(posedge clk) begin
			vsd[g+1] <= vsd[g];
			vs[g+1] <= vs[g];
		end
	end

	// sub-angles
	logic signed [DW-1:0] z0_s4, z1_s4;
	logic [SW-1:0] s_s4;
	side_t sd_s4;
	logic signed [DW+25:0] m0, m1;
	always_comb begin
		m0 = (DW+26)'(vz[NST]) * $signed({1'b0, OneF - vsd[NST].t});
		m1 = (DW+26)'(vz[NST]) * $signed({1'b0, vsd[NST].t});
	end
	always_ff @(posedge clk) begin
		z0_s4 <= DW'(m0 >>> FRAC_BITS);
		z1_s4 <= DW'(m1 >>> FRAC_BITS);
		s_s4 <= vs[NST];
		sd_s4 <= vsd[NST];
	end

	// rotation chains: two sines
	logic signed [DW-1:0] ax [NST+1], ay [NST+1], az [NST+1];
	logic signed [DW-1:0] bx [NST+1], by [NST+1], bz [NST+1];
	side_t rsd [NST+1];
	logic [SW-1:0] rs [NST+1];
	assign ax[0] = qslerp_pkg::GainW; assign ay[0] = '0; assign az[0] = z0_s4;
	assign bx[0] = qslerp_pkg::GainW; assign by[0] = '0; assign bz[0] = z1_s4;
	assign rsd[0] = sd_s4;
	assign rs[0] = s_s4;
	for (genvar g = 0; g < NST; g++) begin : g_rot
		qslerp_cordic_cell #(.Idx(g), .Vec(1'b0)) u_c0 (
			.clk(clk), .x_i(ax[g]), .y_i(ay[g]), .z_i(az[g]),
			.x_q(ax[g+1]), .y_q(ay[g+1]), .z_q(az[g+1]));
		qslerp_cordic_cell #(.Idx(g), .Vec(1'b0)) u_c1 (
			.clk(clk), .x_i(bx[g]), .y_i(by[g]), .z_i(bz[g]),
			.x_q(bx[g+1]), .y_q(by[g+1]), .z_q(bz[g+1]));
		always_ff @(posedge clk) begin
			rsd[g+1] <= rsd[g];
			rs[g+1] <= rs[g];
		end
	end

	// divider setup: magnitudes shifted by 30
	logic [63:0] n0_s5, n1_s5;
	logic ng0_s5, ng1_s5;
	logic [SW-1:0] d_s5;
	side_t sd_n5;
	side_t sd_s5;
	logic signed [DW-1:0] y0, y1;
	always_comb begin
		y0 = ay[NST];
		y1 = by[NST];
		sd_n5 = rsd[NST];
		if (rs[NST] == '0) sd_n5.lin = 1'b1;
	end
	always_ff @(posedge clk) begin
		ng0_s5 <= y0[DW-1];
		ng1_s5 <= y1[DW-1];
		n0_s5 <= 64'(y0[DW-1] ? -y0 : y0) << qslerp_pkg::Wf;
		n1_s5 <= 64'(y1[DW-1] ? -y1 : y1) << qslerp_pkg::Wf;
		d_s5 <= rs[NST];
		sd_s5 <= sd_n5;
	end

	// divider chains
	logic [63:0] dn0 [DIVN+1], dn1 [DIVN+1];
	logic [SW:0] dr0 [DIVN+1], dr1 [DIVN+1];
	logic [SW-1:0] dd0 [DIVN+1], dd1 [DIVN+1];
	logic [33:0] dq0 [DIVN+1], dq1 [DIVN+1];
	side_t dsd [DIVN+1];
	logic dng0 [DIVN+1], dng1 [DIVN+1];
	assign dn0[0] = n0_s5; assign dr0[0] = '0; assign dd0[0] = d_s5; assign dq0[0] = '0;
	assign dn1[0] = n1_s5; assign dr1[0] = '0; assign dd1[0] = d_s5; assign dq1[0] = '0;
	assign dsd[0] = sd_s5;
	assign dng0[0] = ng0_s5;
	assign dng1[0] = ng1_s5;
	for (genvar g = 0; g < DIVN; g++) begin : g_div
		qslerp_div_cell #(.Idx(g)) u_d0 (
			.clk(clk), .num_i(dn0[g]), .rem_i(dr0[g]), .den_i(dd0[g]), .quo_i(dq0[g]),
			.num_q(dn0[g+1]), .rem_q(dr0[g+1]), .den_q(dd0[g+1]), .quo_q(dq0[g+1]));
		qslerp_div_cell #(.Idx(g)) u_d1 (
			.clk(clk), .num_i(dn1[g]), .rem_i(dr1[g]), .den_i(dd1[g]), .quo_i(dq1[g]),
			.num_q(dn1[g+1]), .rem_q(dr1[g+1]), .den_q(dd1[g+1]), .quo_q(dq1[g+1]));
		always_ff @(posedge clk) begin
			dsd[g+1] <= dsd[g];
			dng0[g+1] <= dng0[g];
			dng1[g+1] <= dng1[g];
		end
	end

	// weights: clamp, sign, or linear
	logic signed [DW-1:0] k0_s6, k1_s6;
	side_t sd_s6;
	logic signed [DW-1:0] w0, w1;
	always_comb begin
		w0 = (dq0[DIVN] > 34'(qslerp_pkg::TwoOneW)) ? qslerp_pkg::TwoOneW
			: DW'(dq0[DIVN]);
		w1 = (dq1[DIVN] > 34'(qslerp_pkg::TwoOneW)) ? qslerp_pkg::TwoOneW
			: DW'(dq1[DIVN]);
	end
	always_ff @(posedge clk) begin
		sd_s6 <= dsd[DIVN];
		if (dsd[DIVN].lin) begin
			k0_s6 <= DW'(OneF - dsd[DIVN].t) << SH;
			k1_s6 <= DW'(dsd[DIVN].t) << SH;
		end else begin
			k0_s6 <= dng0[DIVN] ? -w0 : w0;
			k1_s6 <= dng1[DIVN] ? -w1 : w1;
		end
	end

	// blend, round, saturate; b negated at full width when flipped
	function automatic logic signed [15:0] blend(input logic signed [15:0] a,
		input logic signed [15:0] b, input logic flip, input logic signed [DW-1:0] k0,
		input logic signed [DW-1:0] k1);
		logic signed [DW+17:0] bb;
		logic signed [DW+17:0] acc;
		logic signed [DW+17:0] r;
		begin
			bb = flip ? -((DW+18)'(b)) : (DW+18)'(b);
			acc = (DW+18)'(a) * (DW+18)'(k0) + bb * (DW+18)'(k1)
				+ ((DW+18)'(1) <<< (qslerp_pkg::Wf - 1));
			r = acc >>> qslerp_pkg::Wf;
			if (r > 32767) return 16'sh7fff;
			if (r < -32768) return -16'sh8000;
			return r[15:0];
		end
	endfunction

	always_ff @(posedge clk) begin
		r_x <= blend(sd_s6.a_x, sd_s6.b_x, sd_s6.flip, k0_s6, k1_s6);
		r_y <= blend(sd_s6.a_y, sd_s6.b_y, sd_s6.flip, k0_s6, k1_s6);
		r_z <= blend(sd_s6.a_z, sd_s6.b_z, sd_s6.flip, k0_s6, k1_s6);
		r_w <= blend(sd_s6.a_w, sd_s6.b_w, sd_s6.flip, k0_s6, k1_s6);
		used_linear <= sd_s6.lin;
		flipped <= sd_s6.flip;
	end

	assign done = vld_q[LAT-1];

	// done follows a request tracked down the valid chain
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_q[LAT-2]))
		else $error("done without tracked request");
	// busy never blocks
	a_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
endmodule
